[design/phs_pkg.sv]
// shared types, constants and codes for the plate heat relaxation sweep block
package phs_pkg;

    // default plate side and port widths
    localparam int PHS_MAX_SIDE = 32;
    localparam int REG_W        = 32;
    localparam int REG_IDX_W    = 3;
    localparam int KIND_W       = 2;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 88;

    // register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_SIDE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_ROW = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LAST_COL  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LAST_ROW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_COL = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TOL       = 3'd5;

    // 100 percent times the q16.16 scale
    localparam logic [22:0] TOL_SCALE = 23'd6553600;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_SWEEP = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_SW_LR,
        ST_SW_SD,
        ST_SW_SUM,
        ST_SW_RELAX,
        ST_SW_CHECK,
        ST_SW_WRITE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_we;
        logic rd_cell;
        logic lr_rd;
        logic sd_rd;
        logic sum_en;
        logic relax_en;
        logic check_en;
        logic wr_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic side_zero;
        logic cell_last;
        logic out_free;
    } t_status;

endpackage

[design/plate_heat_sor_sweep_top.sv]
// top level of the plate heat relaxation solver with stream request and result channels
//
// usage:
//   s_axis carries one request: tuser holds the kind (clear, sweep, read),
//   tdata holds the row and column of a read. m_axis returns exactly one
//   result per request: cell value, largest change, converged flag and the
//   sweep count. the config write port sets the side and edge temperatures
//   and the tolerance; write it only while no request is in flight.
// work per request, one request at a time:
//   read  : the cell is read on the memory read ports, then the result is loaded
//   sweep : each plate cell is read as left and right, then self and down on the
//           two memory read ports, followed by the sum, relax, tolerance products
//           and write-back steps
//   clear : one memory word per cycle over all 4**ceil(log2(MAX_SIDE)) words
// reset: a clearing pass over the whole plate memory runs first with
//   s_axis_tready low; config writes are taken meanwhile.
// stall: a finished result waits in the output register; the next request is
//   accepted and worked on, and only its hand-off waits for m_axis_tready.
module plate_heat_sor_sweep_top
    import phs_pkg::*;
#(
    parameter int MAX_SIDE = PHS_MAX_SIDE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // row [4:0], col [9:5], zero fill
    input  logic [KIND_W-1:0]     s_axis_tuser,  // kind [1:0]
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // cell_value [31:0], max_change [63:32],
                                                 // converged [64], sweep_count [80:65]
    // config write port
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_index,
    input  logic [REG_W-1:0]      i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // state machine: sequences clear passes, reads and the per-cell sweep steps
    phs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // datapath: plate memory, arithmetic, config and the result register
    phs_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_kind   (s_axis_tuser),
        .i_in_row    (s_axis_tdata[4:0]),
        .i_in_col    (s_axis_tdata[9:5]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_status    (w_status)
    );

endmodule

[design/phs_ctrl.sv]
// sequencing state machine for clear passes, cell reads and relaxation sweeps
module phs_ctrl
    import phs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_in_kind,
    input  t_status           i_status,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_kind)
                        KIND_CLEAR: n_state = ST_CLEAR;
                        KIND_SWEEP: n_state = i_status.side_zero ? ST_FINISH : ST_SW_LR;
                        KIND_READ:  n_state = ST_READ;
                        default:    n_state = ST_FINISH;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_FINISH;
            end
            ST_READ:     n_state = ST_FINISH;
            ST_SW_LR:    n_state = ST_SW_SD;
            ST_SW_SD:    n_state = ST_SW_SUM;
            ST_SW_SUM:   n_state = ST_SW_RELAX;
            ST_SW_RELAX: n_state = ST_SW_CHECK;
            ST_SW_CHECK: n_state = ST_SW_WRITE;
            ST_SW_WRITE: n_state = i_status.cell_last ? ST_FINISH : ST_SW_LR;
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_INIT;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT:     o_cmd.clr_we = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CLEAR:    o_cmd.clr_we   = 1'b1;
            ST_READ:     o_cmd.rd_cell  = 1'b1;
            ST_SW_LR:    o_cmd.lr_rd    = 1'b1;
            ST_SW_SD:    o_cmd.sd_rd    = 1'b1;
            ST_SW_SUM:   o_cmd.sum_en   = 1'b1;
            ST_SW_RELAX: o_cmd.relax_en = 1'b1;
            ST_SW_CHECK: o_cmd.check_en = 1'b1;
            ST_SW_WRITE: o_cmd.wr_en    = 1'b1;
            ST_FINISH:   o_cmd.out_load = i_status.out_free;
            default:     o_cmd = '0;
        endcase
    end

endmodule

[design/phs_dpath.sv]
// plate memory, config registers, relaxation arithmetic and result register
module phs_dpath
    import phs_pkg::*;
#(
    parameter int MAX_SIDE = PHS_MAX_SIDE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [KIND_W-1:0]     i_in_kind,
    input  logic [4:0]            i_in_row,
    input  logic [4:0]            i_in_col,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_index,
    input  logic [REG_W-1:0]      i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output t_status               o_status
);

    localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = $clog2(MAX_SIDE + 1);

    localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

    // configuration
    logic        [5:0]  r_side_cfg;
    logic signed [31:0] r_first_row;
    logic signed [31:0] r_last_col;
    logic signed [31:0] r_last_row;
    logic signed [31:0] r_first_col;
    logic        [31:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_cfg  <= 6'd4;
            r_first_row <= '0;
            r_last_col  <= '0;
            r_last_row  <= '0;
            r_first_col <= '0;
            r_tol       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SIDE:      r_side_cfg  <= i_cfg_data[5:0];
                REG_FIRST_ROW: r_first_row <= $signed(i_cfg_data);
                REG_LAST_COL:  r_last_col  <= $signed(i_cfg_data);
                REG_LAST_ROW:  r_last_row  <= $signed(i_cfg_data);
                REG_FIRST_COL: r_first_col <= $signed(i_cfg_data);
                REG_TOL:       r_tol       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [SW-1:0] w_side;
    assign w_side = (32'(r_side_cfg) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(r_side_cfg);

    // item registers
    logic [KIND_W-1:0] r_kind;
    logic [4:0]        r_in_row;
    logic [4:0]        r_in_col;
    logic              r_rd_ok;
    logic [15:0]       r_sweeps;
    logic              w_rd_ok;

    assign w_rd_ok = (32'(i_in_row) < 32'(w_side)) && (32'(i_in_col) < 32'(w_side));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_in_kind;
            r_in_row <= i_in_row;
            r_in_col <= i_in_col;
            r_rd_ok  <= w_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeps <= '0;
        end else if (i_cmd.load) begin
            if (i_in_kind == KIND_CLEAR) begin
                r_sweeps <= '0;
            end else if (i_in_kind == KIND_SWEEP && r_sweeps != 16'hFFFF) begin
                r_sweeps <= r_sweeps + 16'd1;
            end
        end
    end

    // sweep position
    logic [IW-1:0] r_row;
    logic [IW-1:0] r_col;
    logic          w_row_first;
    logic          w_col_first;
    logic          w_row_last;
    logic          w_col_last;

    assign w_row_first = (r_row == '0);
    assign w_col_first = (r_col == '0);
    assign w_row_last  = (32'(r_row) + 32'd1) == 32'(w_side);
    assign w_col_last  = (32'(r_col) + 32'd1) == 32'(w_side);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.wr_en) begin
            if (w_row_last) begin
                r_row <= '0;
                r_col <= r_col + IW'(1);
            end else begin
                r_row <= r_row + IW'(1);
            end
        end
    end

    // clear pass address
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // plate memory: one write port, two registered read ports
    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [AW-1:0] w_addr_a;
    logic [AW-1:0] w_addr_b;
    logic [IW-1:0] w_col_dn;
    logic [IW-1:0] w_col_up;
    logic [IW-1:0] w_row_up;
    logic [31:0]   w_rd_row32;
    logic [31:0]   w_rd_col32;
    logic signed [31:0] r_nv;

    assign w_col_dn   = r_col - IW'(1);
    assign w_col_up   = r_col + IW'(1);
    assign w_row_up   = r_row + IW'(1);
    assign w_rd_row32 = 32'(r_in_row);
    assign w_rd_col32 = 32'(r_in_col);

    assign w_we    = i_cmd.clr_we | i_cmd.wr_en;
    assign w_waddr = i_cmd.clr_we ? r_clr_addr : {r_row, r_col};
    assign w_wdata = i_cmd.clr_we ? 32'd0 : r_nv;

    always_comb begin
        if (i_cmd.rd_cell) begin
            w_addr_a = {w_rd_row32[IW-1:0], w_rd_col32[IW-1:0]};
            w_addr_b = {w_rd_row32[IW-1:0], w_rd_col32[IW-1:0]};
        end else if (i_cmd.lr_rd) begin
            w_addr_a = {r_row, w_col_dn};
            w_addr_b = {r_row, w_col_up};
        end else begin
            w_addr_a = {r_row, r_col};
            w_addr_b = {w_row_up, r_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_cell || i_cmd.lr_rd || i_cmd.sd_rd) begin
            r_rd_a <= r_mem[w_addr_a];
            r_rd_b <= r_mem[w_addr_b];
        end
    end

    // neighbor capture and sum
    logic signed [31:0] r_left;
    logic signed [31:0] r_right;
    logic signed [31:0] r_up;
    logic signed [31:0] r_old;
    logic signed [33:0] r_sum;
    logic signed [31:0] w_up;
    logic signed [31:0] w_down;

    assign w_up   = w_row_first ? r_first_row : r_up;
    assign w_down = w_row_last ? r_last_row : $signed(r_rd_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sd_rd) begin
            r_left  <= w_col_first ? r_first_col : $signed(r_rd_a);
            r_right <= w_col_last ? r_last_col : $signed(r_rd_b);
        end
        if (i_cmd.sum_en) begin
            r_sum <= 34'(w_up) + 34'(w_down) + 34'(r_left) + 34'(r_right);
            r_old <= $signed(r_rd_a);
        end
    end

    // over-relaxation: floor((3*floor(sum/4) - old) / 2), saturated
    logic signed [31:0] w_avg;
    logic signed [34:0] w_avg35;
    logic signed [34:0] w_t;
    logic signed [33:0] w_h;
    logic signed [31:0] w_sat;

    assign w_avg   = r_sum[33:2];
    assign w_avg35 = 35'(w_avg);
    assign w_t     = (w_avg35 <<< 1) + w_avg35 - 35'(r_old);
    assign w_h     = w_t[34:1];

    always_comb begin
        if (w_h > SAT_HI) begin
            w_sat = SAT_HI[31:0];
        end else if (w_h < SAT_LO) begin
            w_sat = SAT_LO[31:0];
        end else begin
            w_sat = w_h[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.relax_en) begin
            r_nv <= w_sat;
        end
    end

    // change magnitude and relative tolerance products
    logic signed [32:0] w_diff;
    logic signed [32:0] w_ndiff;
    logic signed [32:0] w_nv33;
    logic signed [32:0] w_nnv;
    logic        [31:0] w_d;
    logic        [31:0] w_mag;
    logic        [31:0] r_d;
    logic        [54:0] r_lhs;
    logic        [63:0] r_rhs;

    assign w_diff  = 33'(r_nv) - 33'(r_old);
    assign w_ndiff = -w_diff;
    assign w_d     = w_diff[32] ? w_ndiff[31:0] : w_diff[31:0];
    assign w_nv33  = 33'(r_nv);
    assign w_nnv   = -w_nv33;
    assign w_mag   = w_nv33[32] ? w_nnv[31:0] : w_nv33[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.check_en) begin
            r_d   <= w_d;
            r_lhs <= 55'(w_d) * 55'(TOL_SCALE);
            r_rhs <= 64'(r_tol) * 64'(w_mag);
        end
    end

    // sweep summary
    logic [31:0] r_maxc;
    logic        r_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_maxc <= '0;
            r_ok   <= 1'b1;
        end else if (i_cmd.wr_en) begin
            if (r_d > r_maxc) r_maxc <= r_d;
            if (64'(r_lhs) > r_rhs) r_ok <= 1'b0;
        end
        if (i_cmd.wr_en) begin
            r_up <= r_nv;
        end
    end

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [31:0]           w_cell;
    logic [31:0]           w_maxc;
    logic                  w_conv;

    assign w_cell = (r_kind == KIND_READ && r_rd_ok) ? r_rd_a : 32'd0;
    assign w_maxc = (r_kind == KIND_SWEEP) ? r_maxc : 32'd0;
    assign w_conv = (r_kind == KIND_SWEEP) ? r_ok : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {7'd0, r_sweeps, w_conv, w_maxc, w_cell};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.clr_last  = (r_clr_addr == {AW{1'b1}});
    assign o_status.side_zero = (w_side == '0);
    assign o_status.cell_last = w_row_last && w_col_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

[design/phs_checker.sv]
// port-level assertions for the plate heat solver and their bind to the top level
module phs_checker
    import phs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [KIND_W-1:0]     s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  i_cfg_we,
    input logic [REG_IDX_W-1:0]  i_cfg_index,
    input logic [REG_W-1:0]      i_cfg_data
);

    // reset empties the result register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // the clearing pass after reset holds off requests
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("request taken during reset clearing pass");

    // one request at a time: ready drops after every accepted request
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a nonzero cell value comes only from a read, which reports no largest change and no converged flag
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[31:0] != 32'd0) |-> (m_axis_tdata[64:32] == 33'd0))
        else $error("read result carries sweep figures");

endmodule

bind plate_heat_sor_sweep_top phs_checker u_phs_checker (.*);

[bench/tb_top.sv]
// self-checking stream bench for the plate heat relaxation sweep block
module tb_top;
    import phs_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 8;
    // slowest correct run: twelve random phases, each with at most four side-32
    // sweeps and at most one clear per request, under the slowest receiver
    // pattern, plus the directed part, the long hold and the clearing pass
    // after reset
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int TAIL_CYCLES    = 50;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_PHASE     = 1;
    localparam int RAND_PHASES    = 12;
    localparam int RAND_PER_PHASE = 21;
    localparam int MAX_PRINTS     = 40;
    localparam int PLATE_WORDS    = PHS_MAX_SIDE * PHS_MAX_SIDE;
    localparam int COUNT_RUN      = 6;

    localparam logic [15:0]          COUNT_SAT    = 16'hffff;
    localparam longint unsigned      PCT_SCALE    = 64'd6553600;  // 100 percent in q16.16
    localparam longint               SAT_HI       = 64'sd2147483647;
    localparam longint               SAT_LO       = -64'sd2147483647 - 64'sd1;
    localparam logic [KIND_W-1:0]    KIND_SPARE   = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [REG_W-1:0]     T_MAX        = 32'h7fff_ffff;
    localparam logic [REG_W-1:0]     T_MIN        = 32'h8000_0000;
    localparam logic [REG_W-1:0]     T_HUNDRED    = 32'h0064_0000;  // 100.0
    localparam logic [REG_W-1:0]     T_NEG_FIFTY  = 32'hffce_0000;  // -50.0
    localparam logic [REG_W-1:0]     T_ONE_HALF   = 32'h0001_8000;  // 1.5
    localparam logic [REG_W-1:0]     TOL_ONE_PCT  = 32'h0001_0000;
    localparam logic [REG_W-1:0]     TOL_LOOSEST  = 32'hffff_ffff;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [4:0]        row;
        logic [4:0]        col;
    } t_plate_req;

    typedef struct packed {
        logic [31:0] cell_value;
        logic [31:0] max_change;
        logic        converged;
        logic [15:0] sweep_count;
    } t_plate_res;

    // block ports, all inputs known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // row [4:0], col [9:5], zero fill
    logic [KIND_W-1:0]     s_axis_tuser  = '0;  // kind [1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // cell_value [31:0], max_change [63:32],
                                                // converged [64], sweep_count [80:65]
    logic                  i_cfg_we      = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [REG_W-1:0]      i_cfg_data    = '0;

    // requests waiting to be offered and results waiting to arrive
    t_plate_req request_queue [$];
    t_plate_res expected_results [$];

    // mirror of the plate and its registers
    logic signed [31:0] plate_model [PLATE_WORDS];
    logic [15:0]        sweeps_model;
    logic [5:0]         side_reg;
    logic signed [31:0] t_first_row, t_last_col, t_last_row, t_first_col;
    logic [31:0]        tol_reg;

    // bookkeeping
    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          cfg_writes      = 0;
    int          kind_seen [4]   = '{0, 0, 0, 0};
    int unsigned cycle_count     = 0;

    // sender and receiver pacing
    t_plate_req  drive_req;
    t_plate_req  seen_req;
    int          burst_left  = 0;
    int          gap_left    = 0;
    logic        want_hold   = 1'b0;
    logic        hold_done   = 1'b0;
    int          hold_left   = 0;
    logic [8:0]  ready_phase = '0;

    plate_heat_sor_sweep_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // temperature of a neighbour: an edge register outside the plate, else a cell
    function automatic longint neighbour_temp(int r, int c, int s);
        if (r < 0) return longint'(t_first_row);
        if (r >= s) return longint'(t_last_row);
        if (c < 0) return longint'(t_first_col);
        if (c >= s) return longint'(t_last_col);
        return longint'(plate_model[r * PHS_MAX_SIDE + c]);
    endfunction

    // applies one request to the mirrored plate and returns the result it causes
    function automatic t_plate_res apply_request(t_plate_req rq);
        t_plate_res      res;
        int              s;
        longint          sum, avg, old_v, nv, diff;
        longint unsigned chg, mag, worst;
        logic            all_ok;
        res    = '0;
        worst  = 0;
        all_ok = 1'b1;
        s      = (side_reg > PHS_MAX_SIDE) ? PHS_MAX_SIDE : int'(side_reg);
        case (rq.kind)
            KIND_CLEAR: begin
                for (int i = 0; i < PLATE_WORDS; i++) plate_model[i] = '0;
                sweeps_model = '0;
            end
            KIND_SWEEP: begin
                // column by column, new values feed the cells after them
                for (int c = 0; c < s; c++) begin
                    for (int r = 0; r < s; r++) begin
                        old_v = longint'(plate_model[r * PHS_MAX_SIDE + c]);
                        sum   = neighbour_temp(r - 1, c, s) + neighbour_temp(r + 1, c, s)
                              + neighbour_temp(r, c - 1, s) + neighbour_temp(r, c + 1, s);
                        avg   = sum >>> 2;
                        nv    = (3 * avg - old_v) >>> 1;
                        if (nv > SAT_HI) nv = SAT_HI;
                        if (nv < SAT_LO) nv = SAT_LO;
                        diff  = nv - old_v;
                        chg   = (diff < 0) ? -diff : diff;
                        mag   = (nv < 0) ? -nv : nv;
                        if (chg > worst) worst = chg;
                        // exact relative test; a zero new value passes only with no change
                        if (chg * PCT_SCALE > 64'(tol_reg) * mag) all_ok = 1'b0;
                        plate_model[r * PHS_MAX_SIDE + c] = nv[31:0];
                    end
                end
                if (sweeps_model != COUNT_SAT) sweeps_model = sweeps_model + 16'd1;
                res.max_change = worst[31:0];
                res.converged  = all_ok;
            end
            KIND_READ: begin
                if (int'(rq.row) < s && int'(rq.col) < s)
                    res.cell_value = plate_model[int'(rq.row) * PHS_MAX_SIDE + int'(rq.col)];
            end
            default: ;
        endcase
        res.sweep_count = sweeps_model;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch in %0s at result %0d: got %h expected %h",
                     what, results_checked, got, want);
    endtask

    task automatic check_result(logic [OUT_DATA_W-1:0] word);
        t_plate_res exp_r;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request waiting", word[31:0], '0);
            return;
        end
        exp_r = expected_results.pop_front();
        results_checked++;
        if (word[31:0] !== exp_r.cell_value)
            report_mismatch("cell_value", word[31:0], exp_r.cell_value);
        if (word[63:32] !== exp_r.max_change)
            report_mismatch("max_change", word[63:32], exp_r.max_change);
        if (word[64] !== exp_r.converged)
            report_mismatch("converged", 32'(word[64]), 32'(exp_r.converged));
        if (word[80:65] !== exp_r.sweep_count)
            report_mismatch("sweep_count", 32'(word[80:65]), 32'(exp_r.sweep_count));
    endtask

    // register write, mirrored at once since writes happen only while idle
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_SIDE:      side_reg    = value[5:0];
            REG_FIRST_ROW: t_first_row = value;
            REG_LAST_COL:  t_last_col  = value;
            REG_LAST_ROW:  t_last_row  = value;
            REG_FIRST_COL: t_first_col = value;
            REG_TOL:       tol_reg     = value;
            default: ;     // unknown index, ignored by the block
        endcase
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void queue_request(logic [KIND_W-1:0] kind, logic [4:0] row,
                                          logic [4:0] col);
        t_plate_req rq;
        rq.kind = kind;
        rq.row  = row;
        rq.col  = col;
        request_queue.push_back(rq);
    endfunction

    // sampled on the falling edge so that every clocked update has settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    function automatic logic [31:0] pick_temp();
        case ($urandom_range(0, 5))
            0:       return T_MAX;
            1:       return T_MIN;
            2, 3:    return 32'($urandom_range(0, 32'h00c8_0000)) - T_HUNDRED;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_tol();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return TOL_LOOSEST;
            2, 3:    return 32'($urandom_range(0, 32'h000a_0000));
            default: return $urandom();
        endcase
    endfunction

    // side register value: mostly small plates, now and then large or oversized,
    // upper data bits random since the register keeps only six of them
    function automatic logic [31:0] pick_side();
        logic [31:0] value;
        value = $urandom();
        case ($urandom_range(0, 19))
            0:       value[5:0] = '0;
            1:       value[5:0] = 6'($urandom_range(32, 63));
            2:       value[5:0] = 6'($urandom_range(9, 31));
            default: value[5:0] = 6'($urandom_range(1, 8));
        endcase
        return value;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                drive_req      = request_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_DATA_W - 10){1'b0}}, drive_req.col, drive_req.row};
                s_axis_tuser  <= drive_req.kind;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotates through always ready, coin flip, one in eight and three in four;
    // a single long hold-off lets the block fill up and stall its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            ready_phase <= ready_phase + 9'd1;
            if (want_hold && !hold_done) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                case (ready_phase[8:7])
                    2'd0:    m_axis_tready <= 1'b1;
                    2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2'd2:    m_axis_tready <= (ready_phase[2:0] == 3'd0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // monitor: results are checked before the request of the same edge is added
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                seen_req.kind = s_axis_tuser;
                seen_req.row  = s_axis_tdata[4:0];
                seen_req.col  = s_axis_tdata[9:5];
                kind_seen[seen_req.kind]++;
                expected_results.push_back(apply_request(seen_req));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int s;
        int pick;
        int sweeps_left;
        for (int i = 0; i < PLATE_WORDS; i++) plate_model[i] = '0;
        sweeps_model = '0;
        side_reg     = 6'd4;
        t_first_row  = '0;
        t_last_col   = '0;
        t_last_row   = '0;
        t_first_col  = '0;
        tol_reg      = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // mixed edges on a 3x3 plate, unknown indexes must not disturb anything
        write_reg(REG_SIDE, 32'd3);
        write_reg(REG_FIRST_ROW, T_HUNDRED);
        write_reg(REG_LAST_COL, T_NEG_FIFTY);
        write_reg(REG_LAST_ROW, T_ONE_HALF);
        write_reg(REG_FIRST_COL, T_MAX);
        write_reg(REG_TOL, TOL_ONE_PCT);
        write_reg(REG_SPARE_LO, 32'd1);
        write_reg(REG_SPARE_HI, T_MIN);
        queue_request(KIND_READ, 5'd0, 5'd0);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        queue_request(KIND_READ, 5'd2, 5'd2);
        queue_request(KIND_READ, 5'd3, 5'd0);     // just below the plate
        queue_request(KIND_READ, 5'd31, 5'd31);
        queue_request(KIND_SPARE, 5'd31, 5'd31);
        queue_request(KIND_SWEEP, 5'd31, 5'd31);
        queue_request(KIND_READ, 5'd1, 5'd2);
        queue_request(KIND_CLEAR, 5'd0, 5'd0);
        queue_request(KIND_READ, 5'd1, 5'd2);
        wait_idle();

        // single cell walks 0 -> 1 -> -1 -> 0: a zero new value with a change
        write_reg(REG_SIDE, 32'd1);
        write_reg(REG_FIRST_ROW, 32'd4);
        write_reg(REG_LAST_COL, '0);
        write_reg(REG_LAST_ROW, '0);
        write_reg(REG_FIRST_COL, '0);
        write_reg(REG_TOL, TOL_LOOSEST);
        queue_request(KIND_CLEAR, 5'd0, 5'd0);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        wait_idle();
        write_reg(REG_FIRST_ROW, '0);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);    // zero value, zero change
        queue_request(KIND_READ, 5'd0, 5'd0);
        wait_idle();

        // empty plate: nothing swept, still counted
        write_reg(REG_SIDE, 32'd0);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        queue_request(KIND_READ, 5'd0, 5'd0);
        wait_idle();

        // extreme edges saturate the single cell high, then low
        write_reg(REG_SIDE, 32'd1);
        write_reg(REG_FIRST_ROW, T_MAX);
        write_reg(REG_LAST_COL, T_MAX);
        write_reg(REG_LAST_ROW, T_MAX);
        write_reg(REG_FIRST_COL, T_MAX);
        write_reg(REG_TOL, '0);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        queue_request(KIND_READ, 5'd0, 5'd0);
        wait_idle();
        write_reg(REG_FIRST_ROW, T_MIN);
        write_reg(REG_LAST_COL, T_MIN);
        write_reg(REG_LAST_ROW, T_MIN);
        write_reg(REG_FIRST_COL, T_MIN);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        queue_request(KIND_READ, 5'd0, 5'd0);
        wait_idle();

        // oversized side falls back to the full plate
        write_reg(REG_SIDE, 32'hffff_ffff);
        write_reg(REG_FIRST_COL, T_HUNDRED);
        queue_request(KIND_SWEEP, 5'd0, 5'd0);
        queue_request(KIND_READ, 5'd31, 5'd31);
        wait_idle();

        // sweep counter restarts on a clear, unused kinds leave it alone
        write_reg(REG_SIDE, 32'd0);
        queue_request(KIND_CLEAR, 5'd0, 5'd0);
        for (int i = 0; i < COUNT_RUN; i++)
            queue_request(KIND_SWEEP, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        queue_request(KIND_SPARE, 5'd0, 5'd0);
        queue_request(KIND_CLEAR, 5'd0, 5'd0);
        queue_request(KIND_SPARE, 5'd0, 5'd0);
        wait_idle();

        // random phases, plate contents carried over between settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_SIDE, pick_side());
            if (p == HOLD_PHASE) write_reg(REG_SIDE, 32'($urandom_range(1, 4)));
            if ($urandom_range(0, 3) != 0) write_reg(REG_FIRST_ROW, pick_temp());
            if ($urandom_range(0, 3) != 0) write_reg(REG_LAST_COL, pick_temp());
            if ($urandom_range(0, 3) != 0) write_reg(REG_LAST_ROW, pick_temp());
            if ($urandom_range(0, 3) != 0) write_reg(REG_FIRST_COL, pick_temp());
            if ($urandom_range(0, 3) != 0) write_reg(REG_TOL, pick_tol());
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO,
                          $urandom());
            if (p == HOLD_PHASE) want_hold = 1'b1;
            s = (side_reg > PHS_MAX_SIDE) ? PHS_MAX_SIDE : int'(side_reg);
            // large plates sweep slowly, so only a handful of sweeps there
            sweeps_left = (s > 16) ? 4 : RAND_PER_PHASE;
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    queue_request(KIND_CLEAR, 5'($urandom_range(0, 31)),
                                  5'($urandom_range(0, 31)));
                end else if (pick < 45 && sweeps_left > 0) begin
                    queue_request(KIND_SWEEP, 5'($urandom_range(0, 31)),
                                  5'($urandom_range(0, 31)));
                    sweeps_left--;
                end else if (pick < 95) begin
                    if (s > 0 && $urandom_range(0, 4) != 0)
                        queue_request(KIND_READ, 5'($urandom_range(0, s - 1)),
                                      5'($urandom_range(0, s - 1)));
                    else
                        queue_request(KIND_READ, 5'($urandom_range(0, 31)),
                                      5'($urandom_range(0, 31)));
                end else begin
                    queue_request(KIND_SPARE, 5'($urandom_range(0, 31)),
                                  5'($urandom_range(0, 31)));
                end
            end
            wait_idle();
        end

        // drain, then watch for stray results
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 32'(expected_results.size()), '0);

        $display("covered %0d requests: %0d clear, %0d sweep, %0d read, %0d unused kind",
                 kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3],
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("%0d register writes, %0d results compared, %0d mismatches",
                 cfg_writes, results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
